>>> hdl/kese_pkg.sv
// Shared constants and types for the key escape sequence encoder.
`default_nettype none

package kese_pkg;

  localparam int unsigned SEQ_MAX = 7;
  localparam int unsigned LEN_W   = 3;

  // Sequence bytes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SS3   = 8'h4F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_BTAB  = 8'h5A;
  localparam logic [7:0] CH_F1FIN = 8'h50;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_HOME  = 8'h48;
  localparam logic [7:0] CH_END   = 8'h46;

  // Virtual key codes
  localparam logic [7:0] VK_BACK  = 8'h08;
  localparam logic [7:0] VK_TAB   = 8'h09;
  localparam logic [7:0] VK_ENTER = 8'h0D;
  localparam logic [7:0] VK_ESC   = 8'h1B;
  localparam logic [7:0] VK_PGUP  = 8'h21;
  localparam logic [7:0] VK_PGDN  = 8'h22;
  localparam logic [7:0] VK_END   = 8'h23;
  localparam logic [7:0] VK_HOME  = 8'h24;
  localparam logic [7:0] VK_LEFT  = 8'h25;
  localparam logic [7:0] VK_UP    = 8'h26;
  localparam logic [7:0] VK_RGT   = 8'h27;
  localparam logic [7:0] VK_DOWN  = 8'h28;
  localparam logic [7:0] VK_INS   = 8'h2D;
  localparam logic [7:0] VK_DEL   = 8'h2E;
  localparam logic [7:0] VK_A     = 8'h41;
  localparam logic [7:0] VK_Z     = 8'h5A;
  localparam logic [7:0] VK_F1    = 8'h70;
  localparam logic [7:0] VK_F2    = 8'h71;
  localparam logic [7:0] VK_F4    = 8'h73;
  localparam logic [7:0] VK_F5    = 8'h74;
  localparam logic [7:0] VK_F12   = 8'h7B;

  localparam logic [7:0] CTRL_OFS  = 8'h40;
  localparam logic [7:0] LOWER_OFS = 8'h20;

  // Tilde codes of the editing keys
  localparam logic [3:0] TC_INSERT = 4'd2;
  localparam logic [3:0] TC_DELETE = 4'd3;
  localparam logic [3:0] TC_PGUP   = 4'd5;
  localparam logic [3:0] TC_PGDN   = 4'd6;

  // F5..F12 codes 15,17,18,19,20,21,23,24 split into decimal digits, index 0 = F5
  localparam logic [7:0][3:0] FKEY_TENS = {4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1};
  localparam logic [7:0][3:0] FKEY_ONES = {4'd4, 4'd3, 4'd1, 4'd0, 4'd9, 4'd8, 4'd7, 4'd5};
  localparam logic [2:0]      FKEY_BASE = 3'd4;

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;  // bytes[0] goes out first
    logic [LEN_W-1:0]        len;    // zero: key gives nothing
  } kese_seq_t;

endpackage : kese_pkg

`default_nettype wire

>>> hdl/kese_if.sv
// Handshake interfaces for key events and sequence bytes.
`default_nettype none

interface kese_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       shift_held;
  logic       ctrl_held;
  logic       alt_held;

  modport source (output valid, key_code, shift_held, ctrl_held, alt_held, input ready);
  modport sink   (input valid, key_code, shift_held, ctrl_held, alt_held, output ready);
endinterface : kese_key_if

interface kese_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface : kese_byte_if

`default_nettype wire

>>> hdl/kese_encode.sv
// Combinational mapping of one registered key event to its byte sequence.
`default_nettype none

module kese_encode
  import kese_pkg::*;
(
  input  wire logic [7:0] key_code,
  input  wire logic       shift_held,
  input  wire logic       ctrl_held,
  input  wire logic       alt_held,
  input  wire logic       ss3_sel,
  output kese_seq_t       seq
);

  always_comb begin
    logic [SEQ_MAX-1:0][7:0] b;
    logic [LEN_W-1:0]        n;
    logic [7:0]              mod_ch;
    logic                    has_mod;
    logic                    letter;
    logic                    is_cur;
    logic [7:0]              cur_fin;
    logic                    cur_ss3;
    logic                    is_til;
    logic                    til_tens_en;
    logic [3:0]              til_tens;
    logic [3:0]              til_ones;
    logic [2:0]              fidx;

    b           = '0;
    n           = '0;
    has_mod     = shift_held | ctrl_held | alt_held;
    mod_ch      = CH_ONE + {5'd0, ctrl_held, alt_held, shift_held};
    letter      = (key_code >= VK_A) && (key_code <= VK_Z);
    is_cur      = 1'b0;
    cur_fin     = CH_UP;
    cur_ss3     = ss3_sel;
    is_til      = 1'b0;
    til_tens_en = 1'b0;
    til_tens    = '0;
    til_ones    = '0;
    fidx        = key_code[2:0] - FKEY_BASE;

    priority if (letter && ctrl_held && !alt_held && !shift_held) begin
      b[n] = key_code - CTRL_OFS; n = n + 1'b1;
    end else if (letter && alt_held && !ctrl_held && !shift_held) begin
      b[n] = CH_ESC;                 n = n + 1'b1;
      b[n] = key_code + LOWER_OFS;   n = n + 1'b1;
    end else begin
      unique case (key_code)
        VK_BACK: begin
          if (ctrl_held || alt_held) begin
            b[n] = CH_ESC; n = n + 1'b1;
          end
          b[n] = CH_DEL; n = n + 1'b1;
        end
        VK_TAB: begin
          if (shift_held) begin
            b[n] = CH_ESC;  n = n + 1'b1;
            b[n] = CH_LBRK; n = n + 1'b1;
            b[n] = CH_BTAB; n = n + 1'b1;
          end else begin
            b[n] = CH_TAB;  n = n + 1'b1;
          end
        end
        VK_ENTER: begin b[n] = CH_CR;  n = n + 1'b1; end
        VK_ESC:   begin b[n] = CH_ESC; n = n + 1'b1; end
        VK_UP:    begin is_cur = 1'b1; cur_fin = CH_UP;    end
        VK_DOWN:  begin is_cur = 1'b1; cur_fin = CH_DOWN;  end
        VK_RGT:   begin is_cur = 1'b1; cur_fin = CH_RIGHT; end
        VK_LEFT:  begin is_cur = 1'b1; cur_fin = CH_LEFT;  end
        VK_HOME:  begin is_cur = 1'b1; cur_fin = CH_HOME;  end
        VK_END:   begin is_cur = 1'b1; cur_fin = CH_END;   end
        VK_INS:   begin is_til = 1'b1; til_ones = TC_INSERT; end
        VK_DEL:   begin is_til = 1'b1; til_ones = TC_DELETE; end
        VK_PGUP:  begin is_til = 1'b1; til_ones = TC_PGUP;   end
        VK_PGDN:  begin is_til = 1'b1; til_ones = TC_PGDN;   end
        default: begin
          if (key_code >= VK_F1 && key_code <= VK_F4) begin
            // F1..F4 take SS3 form whenever unmodified
            is_cur  = 1'b1;
            cur_ss3 = 1'b1;
            cur_fin = CH_F1FIN + {6'd0, key_code[1:0]};
          end else if (key_code >= VK_F5 && key_code <= VK_F12) begin
            is_til      = 1'b1;
            til_tens_en = 1'b1;
            til_tens    = FKEY_TENS[fidx];
            til_ones    = FKEY_ONES[fidx];
          end
        end
      endcase
    end

    if (is_cur) begin
      b[n] = CH_ESC; n = n + 1'b1;
      if (has_mod) begin
        b[n] = CH_LBRK; n = n + 1'b1;
        b[n] = CH_ONE;  n = n + 1'b1;
        b[n] = CH_SEMI; n = n + 1'b1;
        b[n] = mod_ch;  n = n + 1'b1;
      end else begin
        b[n] = cur_ss3 ? CH_SS3 : CH_LBRK; n = n + 1'b1;
      end
      b[n] = cur_fin; n = n + 1'b1;
    end

    if (is_til) begin
      b[n] = CH_ESC;  n = n + 1'b1;
      b[n] = CH_LBRK; n = n + 1'b1;
      if (til_tens_en) begin
        b[n] = CH_ZERO + {4'd0, til_tens}; n = n + 1'b1;
      end
      b[n] = CH_ZERO + {4'd0, til_ones}; n = n + 1'b1;
      if (has_mod) begin
        b[n] = CH_SEMI; n = n + 1'b1;
        b[n] = mod_ch;  n = n + 1'b1;
      end
      b[n] = CH_TILDE; n = n + 1'b1;
    end

    seq.bytes = b;
    seq.len   = n;
  end

endmodule : kese_encode

`default_nettype wire

>>> hdl/kese_serial.sv
// Sequence holding register and byte output register, one byte per cycle while out_seq is not stalled.
`default_nettype none

module kese_serial
  import kese_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         seq_valid,
  input  wire kese_seq_t    seq,
  output logic              seq_take,
  kese_byte_if.source       out_seq
);

  logic                    busy_r,      busy_nxt;
  logic [LEN_W-1:0]        rem_r,       rem_nxt;
  logic [SEQ_MAX-1:0][7:0] bytes_r,     bytes_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_byte_r,  out_byte_nxt;
  logic                    last_r,      last_nxt;

  logic out_free;
  logic emit;
  logic seq_free;
  logic load;

  assign out_free = !out_valid_r || out_seq.ready;
  assign emit     = busy_r && out_free;
  // holding register frees up in the cycle its final byte moves out
  assign seq_free = !busy_r || (emit && rem_r == LEN_W'(1));
  assign seq_take = seq_valid && (seq.len == '0 || seq_free);
  assign load     = seq_valid && seq.len != '0 && seq_free;

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    bytes_nxt     = bytes_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = bytes_r[0];
      last_nxt      = (rem_r == LEN_W'(1));
      bytes_nxt     = bytes_r >> 8;
      rem_nxt       = rem_r - 1'b1;
      if (rem_r == LEN_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end else if (out_seq.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      busy_nxt  = 1'b1;
      rem_nxt   = seq.len;
      bytes_nxt = seq.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    bytes_r    <= bytes_nxt;
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
  end

  assign out_seq.valid     = out_valid_r;
  assign out_seq.out_byte  = out_byte_r;
  assign out_seq.last_byte = last_r;

endmodule : kese_serial

`default_nettype wire

>>> hdl/key_escape_sequence_encoder_top.sv
// Top level of the key escape sequence encoder.
//
//   channel   direction  form               content
//   in_key    in         valid/ready        key_code, shift_held, ctrl_held, alt_held
//   out_seq   out        valid/ready        out_byte, last_byte (one byte per transfer)
//   cfg_*     in         write enable/data  cursor key mode
//
// A key event is registered, encoded combinationally into a holding register and then
// sent out one byte per cycle while out_seq is not stalled, 0 to 7 bytes per key; the
// output byte register sets that rate. The first byte passes through the key register,
// holding register and output byte register. A key with no sequence is dropped unheld.
// Reset clears all valid flags and the cursor mode bit. out_seq stalls back up through
// the holding register to in_key.ready; no transfer is lost across a stall.
`default_nettype none

module key_escape_sequence_encoder_top
  import kese_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  kese_key_if.sink    in_key,
  kese_byte_if.source out_seq,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data
);

  logic       ev_valid_r, ev_valid_nxt;
  logic [7:0] key_r;
  logic       shift_r;
  logic       ctrl_r;
  logic       alt_r;
  logic       cur_mode_r;

  logic       seq_take;
  logic       in_xfer;
  kese_seq_t  seq;

  assign in_key.ready = !ev_valid_r || seq_take;
  assign in_xfer      = in_key.valid && in_key.ready;

  always_comb begin
    ev_valid_nxt = ev_valid_r;
    if (in_xfer) begin
      ev_valid_nxt = 1'b1;
    end else if (seq_take) begin
      ev_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
      cur_mode_r <= 1'b0;
    end else begin
      ev_valid_r <= ev_valid_nxt;
      if (cfg_wr_en) begin
        cur_mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r   <= in_key.key_code;
      shift_r <= in_key.shift_held;
      ctrl_r  <= in_key.ctrl_held;
      alt_r   <= in_key.alt_held;
    end
  end

  kese_encode u_encode (
    .key_code   (key_r),
    .shift_held (shift_r),
    .ctrl_held  (ctrl_r),
    .alt_held   (alt_r),
    .ss3_sel    (cur_mode_r),
    .seq        (seq)
  );

  kese_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .seq_valid (ev_valid_r),
    .seq       (seq),
    .seq_take  (seq_take),
    .out_seq   (out_seq)
  );

endmodule : key_escape_sequence_encoder_top

`default_nettype wire

>>> hdl/kese_checker.sv
// Port-level checks on the encoder output, bound to the top level.
`default_nettype none

module kese_checker
  import kese_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last_byte
);

  logic             first_r;
  logic [LEN_W-1:0] run_r;
  logic             xfer;

  assign xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      run_r   <= '0;
    end else if (xfer) begin
      first_r <= last_byte;
      run_r   <= last_byte ? '0 : run_r + 1'b1;
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(last_byte))
    else $error("out payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("out valid set straight after reset");

  // every sequence longer than one byte opens with ESC
  a_esc_lead: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && first_r && !last_byte |-> out_byte == CH_ESC)
    else $error("multi-byte sequence without leading ESC");

  a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && run_r == LEN_W'(SEQ_MAX - 1) |-> last_byte)
    else $error("sequence longer than seven bytes");

endmodule : kese_checker

bind key_escape_sequence_encoder_top kese_checker u_kese_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_seq.valid),
  .out_ready (out_seq.ready),
  .out_byte  (out_seq.out_byte),
  .last_byte (out_seq.last_byte)
);

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the key escape sequence encoder: keyed stimulus, byte-stream scoreboard.
`default_nettype none

module tb;
  import kese_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int FKEY_TILDE [8] = '{15, 17, 18, 19, 20, 21, 23, 24};
  localparam logic [7:0] NAV_KEYS [14] = '{VK_BACK, VK_TAB, VK_ENTER, VK_ESC,
                                           VK_PGUP, VK_PGDN, VK_END, VK_HOME, VK_LEFT,
                                           VK_UP, VK_RGT, VK_DOWN, VK_INS, VK_DEL};

  typedef enum logic [1:0] {FORM_LITERAL, FORM_CURSOR, FORM_TILDE} seq_form_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       is_last;
  } seq_byte_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  kese_key_if  key_ch ();
  kese_byte_if byte_ch ();

  key_escape_sequence_encoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_key      (key_ch),
    .out_seq     (byte_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  seq_byte_t pending_bytes [$];
  logic      cur_mode;
  logic      bubbles_on;
  int        rx_hold_cycles;
  int        rx_stall_left;
  int        mismatch_count;
  int        cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Expected bytes of one key event, appended to the scoreboard queue
  function automatic void predict_key_bytes(input logic [7:0] k, input logic s, c, a);
    logic [7:0] seq [$];
    logic [3:0] mod_param;
    logic       has_mod;
    logic       ss3;
    logic       letter;
    seq_form_e  form;
    logic [7:0] fin;
    int         code;
    mod_param = {1'b0, c, a, s} + 4'd1;
    has_mod   = s | c | a;
    ss3       = cur_mode;
    letter    = (k >= VK_A) && (k <= VK_Z);
    form      = FORM_LITERAL;
    fin       = 8'h00;
    code      = 0;
    if (letter && c && !a && !s) begin
      seq.push_back(k - CTRL_OFS);
    end else if (letter && a && !c && !s) begin
      seq.push_back(CH_ESC);
      seq.push_back(k + LOWER_OFS);
    end else begin
      case (k)
        VK_BACK: begin
          if (c || a) seq.push_back(CH_ESC);
          seq.push_back(CH_DEL);
        end
        VK_TAB: begin
          if (s) begin
            seq.push_back(CH_ESC);
            seq.push_back(CH_LBRK);
            seq.push_back(CH_BTAB);
          end else begin
            seq.push_back(CH_TAB);
          end
        end
        VK_ENTER: seq.push_back(CH_CR);
        VK_ESC:   seq.push_back(CH_ESC);
        VK_UP:    begin form = FORM_CURSOR; fin = CH_UP;    end
        VK_DOWN:  begin form = FORM_CURSOR; fin = CH_DOWN;  end
        VK_RGT:   begin form = FORM_CURSOR; fin = CH_RIGHT; end
        VK_LEFT:  begin form = FORM_CURSOR; fin = CH_LEFT;  end
        VK_HOME:  begin form = FORM_CURSOR; fin = CH_HOME;  end
        VK_END:   begin form = FORM_CURSOR; fin = CH_END;   end
        VK_INS:   begin form = FORM_TILDE;  code = 2;       end
        VK_DEL:   begin form = FORM_TILDE;  code = 3;       end
        VK_PGUP:  begin form = FORM_TILDE;  code = 5;       end
        VK_PGDN:  begin form = FORM_TILDE;  code = 6;       end
        default: begin
          if (k >= VK_F1 && k <= VK_F4) begin
            // F1..F4 are SS3 when unmodified, whatever the cursor mode
            form = FORM_CURSOR;
            fin  = CH_F1FIN + (k - VK_F1);
            ss3  = 1'b1;
          end else if (k >= VK_F5 && k <= VK_F12) begin
            form = FORM_TILDE;
            code = FKEY_TILDE[k - VK_F5];
          end
        end
      endcase
    end
    if (form == FORM_CURSOR) begin
      seq.push_back(CH_ESC);
      if (has_mod) begin
        seq.push_back(CH_LBRK);
        seq.push_back(CH_ONE);
        seq.push_back(CH_SEMI);
        seq.push_back(CH_ZERO + 8'(mod_param));
      end else begin
        seq.push_back(ss3 ? CH_SS3 : CH_LBRK);
      end
      seq.push_back(fin);
    end else if (form == FORM_TILDE) begin
      seq.push_back(CH_ESC);
      seq.push_back(CH_LBRK);
      if (code >= 10) seq.push_back(CH_ZERO + 8'(code / 10));
      seq.push_back(CH_ZERO + 8'(code % 10));
      if (has_mod) begin
        seq.push_back(CH_SEMI);
        seq.push_back(CH_ZERO + 8'(mod_param));
      end
      seq.push_back(CH_TILDE);
    end
    foreach (seq[i]) pending_bytes.push_back({seq[i], i == seq.size() - 1});
  endfunction

  function automatic logic [7:0] pick_key();
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = $urandom_range(0, 25);
    if (r < 2) return 8'($urandom);
    if (r < 4) return VK_A + 8'(n);
    if (n < 14) return NAV_KEYS[n];
    return VK_F1 + 8'(n - 14);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Offer one key; returns at the edge of its transfer with valid still high
  task automatic send_key(input logic [7:0] k, input logic s, c, a);
    if (bubbles_on && $urandom_range(0, 3) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    key_ch.valid      <= 1'b1;
    key_ch.key_code   <= k;
    key_ch.shift_held <= s;
    key_ch.ctrl_held  <= c;
    key_ch.alt_held   <= a;
    do @(posedge clk); while (!key_ch.ready);
    predict_key_bytes(k, s, c, a);
  endtask

  task automatic send_random_key();
    logic [2:0] mods;
    mods = 3'($urandom);
    send_key(pick_key(), mods[0], mods[1], mods[2]);
  endtask

  // Sender holds off until every outstanding byte is out, then lets any dropped keys drain
  task automatic wait_sequences_done();
    key_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cur_mode(input logic mode);
    wait_sequences_done();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_mode = mode;
  endtask

  task automatic test_directed_keys();
    set_cur_mode(1'b0);
    send_key(VK_A, 1'b0, 1'b1, 1'b0);      // ctrl+A
    send_key(VK_Z, 1'b0, 1'b1, 1'b0);
    send_key(VK_A, 1'b0, 1'b0, 1'b1);      // alt+A
    send_key(VK_Z, 1'b0, 1'b0, 1'b1);
    send_key(VK_A, 1'b0, 1'b0, 1'b0);      // bare letter: nothing
    send_key(VK_Z, 1'b1, 1'b0, 1'b0);      // shifted letter: nothing
    send_key(VK_A, 1'b0, 1'b1, 1'b1);      // ctrl+alt letter: nothing
    send_key(VK_BACK, 1'b0, 1'b0, 1'b0);
    send_key(VK_BACK, 1'b1, 1'b1, 1'b0);
    send_key(VK_TAB, 1'b0, 1'b1, 1'b1);    // tab ignores ctrl and alt
    send_key(VK_TAB, 1'b1, 1'b0, 1'b0);    // back-tab
    send_key(VK_ENTER, 1'b1, 1'b1, 1'b1);
    send_key(VK_ESC, 1'b1, 1'b0, 1'b1);
    send_key(VK_UP, 1'b0, 1'b0, 1'b0);
    send_key(VK_HOME, 1'b1, 1'b1, 1'b0);
    send_key(VK_F1, 1'b0, 1'b0, 1'b0);
    send_key(VK_F4, 1'b0, 1'b0, 1'b1);
    send_key(VK_F5, 1'b0, 1'b0, 1'b0);
    send_key(VK_F12, 1'b1, 1'b1, 1'b1);    // longest sequence
    send_key(VK_INS, 1'b0, 1'b0, 1'b0);
    send_key(VK_PGDN, 1'b1, 1'b0, 1'b0);
    send_key(8'h00, 1'b0, 1'b0, 1'b0);     // unhandled codes
    send_key(8'hFF, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_cursor_modes();
    set_cur_mode(1'b1);
    send_key(VK_UP, 1'b0, 1'b0, 1'b0);
    send_key(VK_DOWN, 1'b0, 1'b0, 1'b0);
    send_key(VK_RGT, 1'b0, 1'b0, 1'b0);
    send_key(VK_LEFT, 1'b0, 1'b0, 1'b0);
    send_key(VK_HOME, 1'b0, 1'b0, 1'b0);
    send_key(VK_END, 1'b0, 1'b0, 1'b0);
    send_key(VK_UP, 1'b0, 1'b1, 1'b0);     // modified keeps CSI form
    send_key(VK_F2, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_keys(input int count, input logic mode);
    set_cur_mode(mode);
    repeat (count) send_random_key();
  endtask

  // Receiver holds off a long stretch so the encoder backs up to its input
  task automatic test_output_stall();
    wait_sequences_done();
    rx_hold_cycles = 150;
    repeat (6) send_key(VK_F12, 1'b1, 1'b1, 1'b1);
    repeat (18) send_random_key();
    wait_sequences_done();
  endtask

  task automatic test_back_to_back();
    bubbles_on = 1'b0;
    test_random_keys(40, 1'($urandom));
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    key_ch.valid       = 1'b0;
    key_ch.key_code    = 8'h00;
    key_ch.shift_held  = 1'b0;
    key_ch.ctrl_held   = 1'b0;
    key_ch.alt_held    = 1'b0;
    cur_mode           = 1'b0;
    bubbles_on         = 1'b1;
    rx_hold_cycles     = 0;
    mismatch_count     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_keys();
    test_cursor_modes();
    test_random_keys(70, 1'b1);
    test_random_keys(70, 1'b0);
    test_output_stall();
    test_random_keys(70, 1'b1);
    test_back_to_back();
    wait_sequences_done();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial byte_ch.ready = 1'b1;
  initial rx_stall_left = 0;

  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      byte_ch.ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      byte_ch.ready <= 1'b0;
    end else if (bubbles_on && $urandom_range(0, 4) == 0) begin
      rx_stall_left = $urandom_range(1, 8) - 1;
      byte_ch.ready <= 1'b0;
    end else begin
      byte_ch.ready <= 1'b1;
    end
  end

  // Each byte transfer is matched against the oldest expected byte
  always @(posedge clk) begin : byte_check
    seq_byte_t want;
    if (rst_n && byte_ch.valid && byte_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                  byte_ch.out_byte, byte_ch.last_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (byte_ch.out_byte !== want.code_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    byte_ch.out_byte, want.code_byte));
        if (byte_ch.last_byte !== want.is_last)
          report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
                                    byte_ch.last_byte, want.is_last, want.code_byte));
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding",
               cycle_count, pending_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule : tb

`default_nettype wire
